[sv/rtwq_pkg.sv]
// shared types, constants and helpers for the release time wakeup queue
`timescale 1ns / 1ps
`default_nettype none
package rtwq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TASK_COUNT_DEF  = 64;

  localparam int TASK_W   = 6;
  localparam int TIME_W   = 64;
  localparam int JOB_W    = 32;
  localparam int MARGIN_W = 32;
  localparam int KIND_W   = 2;

  localparam logic CMD_DELAY = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    EV_QUEUED = 2'd0,
    EV_LATE   = 2'd1,
    EV_WOKEN  = 2'd2,
    EV_FULL   = 2'd3
  } event_kind_t;

  // classified word handed from front to back
  typedef struct packed {
    logic              is_tick;
    logic              late;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] rel;
    logic [TIME_W-1:0] now;
  } cmd_word_t;

  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a,
                                                logic [MARGIN_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - MARGIN_W){1'b0}}, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/rtwq_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rtwq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/rtwq_front.sv]
// input acceptance, classification and two entry command queue
`timescale 1ns / 1ps
`default_nettype none
module rtwq_front import rtwq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              init_done,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_command,
  input  wire logic [TASK_W-1:0] in_task_id,
  input  wire logic [TIME_W-1:0] in_release_time,
  input  wire logic [TIME_W-1:0] in_now,
  output logic                   q_valid,
  output cmd_word_t              q_word,
  input  wire logic              q_pop
);

  cmd_word_t  fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;
  cmd_word_t  word;

  assign in_ready = init_done && (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    word.is_tick = (in_command == CMD_TICK);
    word.late    = (in_release_time <= in_now);
    word.task_id = in_task_id;
    word.rel     = in_release_time;
    word.now     = in_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= word;
    end
  end

endmodule
`default_nettype wire

[sv/rtwq_back.sv]
// sorted release cells, job count store and command sequencer
`timescale 1ns / 1ps
`default_nettype none
module rtwq_back import rtwq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TASK_COUNT  = TASK_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [MARGIN_W-1:0] cfg_wdata,
  input  wire logic                q_valid,
  input  wire cmd_word_t           q_word,
  output logic                     q_pop,
  output logic                     init_done,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KIND_W-1:0]        out_event_kind,
  output logic [TASK_W-1:0]        out_task,
  output logic [JOB_W-1:0]         out_job_number,
  output logic [TIME_W-1:0]        out_next_expiry,
  output logic                     out_last
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TIDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int MODW   = TASK_W + 11;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_EXPSUM, S_EXPCMP, S_JOBRD,
    S_LIMIT, S_WFLAG, S_WEXP, S_WADDR, S_WRD
  } state_t;

  // task id folded onto the job count store by compare and subtract
  function automatic logic [TIDX_W-1:0] task_index(logic [TASK_W-1:0] t);
    logic [MODW-1:0] r;
    r = MODW'(t);
    for (int k = TASK_W - 1; k >= 0; k--) begin
      if (r >= (MODW'(TASK_COUNT) << k)) begin
        r = r - (MODW'(TASK_COUNT) << k);
      end
    end
    return TIDX_W'(r);
  endfunction

  state_t              state_r;
  logic [TIDX_W-1:0]   clr_r;
  logic [FILL_W-1:0]   fill_r;
  logic [TIME_W-1:0]   expiry_r;
  logic [MARGIN_W-1:0] margin_r;
  cmd_word_t           cmd_r;
  event_kind_t         kind_r;
  logic                inc_r;
  logic [TIME_W-1:0]   sum_r;
  logic [QUEUE_DEPTH-1:0] w_r;
  logic [TIME_W-1:0]   slot_rel_r [QUEUE_DEPTH];
  logic [TASK_W-1:0]   slot_tid_r [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] le;
  logic [QUEUE_DEPTH-1:0] wk;
  logic [TIME_W-1:0]   sel_exp;
  logic                sel_any;
  logic                out_free;
  logic                wake_st;
  logic                do_insert;
  logic                do_pop;
  logic                ram_we;
  logic [TIDX_W-1:0]   ram_raddr;
  logic [TIDX_W-1:0]   ram_waddr;
  logic [JOB_W-1:0]    ram_wdata;
  logic [JOB_W-1:0]    ram_rdata;

  assign init_done = (state_r != S_CLEAR);
  assign q_pop     = (state_r == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign wake_st   = (state_r == S_WEXP) || (state_r == S_WADDR) || (state_r == S_WRD);
  assign do_insert = (state_r == S_DECIDE) && !cmd_r.is_tick && !cmd_r.late &&
                     (fill_r != FILL_W'(QUEUE_DEPTH));
  assign do_pop    = (state_r == S_WRD) && out_free;

  assign ram_raddr = wake_st ? task_index(slot_tid_r[0]) : task_index(cmd_r.task_id);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : ram_raddr;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : ram_rdata + JOB_W'(1);
  assign ram_we    = (state_r == S_CLEAR) || do_pop ||
                     ((state_r == S_JOBRD) && out_free && inc_r);

  always_comb begin
    sel_exp = '0;
    sel_any = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (FILL_W'(i) < fill_r) && (slot_rel_r[i] <= cmd_r.rel);
      wk[i] = (FILL_W'(i) < fill_r) && (slot_rel_r[i] <= sum_r);
      // first cell left after the wake burst
      if ((FILL_W'(i) < fill_r) && !w_r[i] &&
          ((i == 0) ? 1'b1 : w_r[(i == 0) ? 0 : i - 1])) begin
        sel_exp = sel_exp | slot_rel_r[i];
        sel_any = 1'b1;
      end
    end
  end

  rtwq_ram #(
    .WIDTH (JOB_W),
    .DEPTH (TASK_COUNT)
  ) u_jobs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sorted cells: equal release times land behind existing ones
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_insert) begin
        if (i == 0) begin
          if (!le[0]) begin
            slot_rel_r[0] <= cmd_r.rel;
            slot_tid_r[0] <= cmd_r.task_id;
          end
        end else if (!le[i]) begin
          if (le[(i == 0) ? 0 : i - 1]) begin
            slot_rel_r[i] <= cmd_r.rel;
            slot_tid_r[i] <= cmd_r.task_id;
          end else begin
            slot_rel_r[i] <= slot_rel_r[(i == 0) ? 0 : i - 1];
            slot_tid_r[i] <= slot_tid_r[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (do_pop && (i < QUEUE_DEPTH - 1)) begin
        slot_rel_r[i] <= slot_rel_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        slot_tid_r[i] <= slot_tid_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      fill_r    <= '0;
      expiry_r  <= '1;
      margin_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        margin_r <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + TIDX_W'(1);
          if (clr_r == TIDX_W'(TASK_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_word;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd_r.is_tick) begin
            state_r <= (cmd_r.now < expiry_r) ? S_IDLE : S_LIMIT;
          end else if (cmd_r.late) begin
            kind_r  <= EV_LATE;
            inc_r   <= 1'b1;
            state_r <= S_JOBRD;
          end else if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
            kind_r  <= EV_FULL;
            inc_r   <= 1'b0;
            state_r <= S_JOBRD;
          end else begin
            fill_r  <= fill_r + FILL_W'(1);
            kind_r  <= EV_QUEUED;
            inc_r   <= 1'b0;
            state_r <= S_EXPSUM;
          end
        end
        S_EXPSUM: begin
          sum_r   <= sat_add(expiry_r, margin_r);
          state_r <= S_EXPCMP;
        end
        S_EXPCMP: begin
          if (slot_rel_r[0] < sum_r) begin
            expiry_r <= slot_rel_r[0];
          end
          state_r <= S_JOBRD;
        end
        S_JOBRD: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_event_kind  <= kind_r;
            out_task        <= cmd_r.task_id;
            out_job_number  <= ram_rdata + JOB_W'(inc_r);
            out_next_expiry <= expiry_r;
            out_last        <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        S_LIMIT: begin
          sum_r   <= sat_add(cmd_r.now, margin_r);
          state_r <= S_WFLAG;
        end
        S_WFLAG: begin
          w_r     <= wk;
          state_r <= S_WEXP;
        end
        S_WEXP: begin
          expiry_r <= sel_any ? sel_exp : '1;
          state_r  <= w_r[0] ? S_WRD : S_IDLE;
        end
        S_WRD: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_event_kind  <= EV_WOKEN;
            out_task        <= slot_tid_r[0];
            out_job_number  <= ram_rdata + JOB_W'(1);
            out_next_expiry <= expiry_r;
            out_last        <= !w_r[1];
            fill_r          <= fill_r - FILL_W'(1);
            w_r             <= w_r >> 1;
            state_r         <= w_r[1] ? S_WADDR : S_IDLE;
          end
        end
        S_WADDR: begin
          // wait state so the next read sees the count just written
          state_r <= S_WRD;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/release_time_wakeup_queue.sv]
// Release time wakeup queue: tasks sorted by 64-bit release time, woken on
// timer ticks.
// Input channel (in_valid/in_ready): a delay word (command 0) queues a task
// or reports a missed release or a full queue; a tick word (command 1) wakes
// every queued task whose release is at or below now plus the wake margin.
// Result channel (out_valid/out_ready): one word per delay, one word per
// woken task on a tick (none for an early or empty tick); out_last marks
// the final word of an input.
// Sequence: a missed or rejected delay gives its word after the job count
// read, a queued one after the expiry sum and compare; a due tick computes
// its limit, latches the wake flags and reloads the expiry before its first
// woken word, and further words are paced by the read-modify-write of the
// job count ram. An early tick goes back to idle after its decision.
// A two word queue sits between acceptance and processing, so inputs are
// taken while earlier ones are still at work or a result waits.
// cfg_we writes the wake margin; write it only while the block is idle.
// Reset: queue emptied, expiry all ones, margin zero; then a clearing pass
// over all TASK_COUNT entries zeroes the job counts, in_ready stays low meanwhile.
// When the receiver stalls the result word is held and processing waits.
`timescale 1ns / 1ps
`default_nettype none
module release_time_wakeup_queue import rtwq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TASK_COUNT  = TASK_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [MARGIN_W-1:0] cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_command,
  input  wire logic [TASK_W-1:0]   in_task_id,
  input  wire logic [TIME_W-1:0]   in_release_time,
  input  wire logic [TIME_W-1:0]   in_now,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KIND_W-1:0]        out_event_kind,
  output logic [TASK_W-1:0]        out_task,
  output logic [JOB_W-1:0]         out_job_number,
  output logic [TIME_W-1:0]        out_next_expiry,
  output logic                     out_last
);

  logic      init_done;
  logic      q_valid;
  logic      q_pop;
  cmd_word_t q_word;

  rtwq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .init_done       (init_done),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_task_id      (in_task_id),
    .in_release_time (in_release_time),
    .in_now          (in_now),
    .q_valid         (q_valid),
    .q_word          (q_word),
    .q_pop           (q_pop)
  );

  rtwq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_COUNT  (TASK_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .q_valid         (q_valid),
    .q_word          (q_word),
    .q_pop           (q_pop),
    .init_done       (init_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_task        (out_task),
    .out_job_number  (out_job_number),
    .out_next_expiry (out_next_expiry),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

[sv/rtwq_checker.sv]
// port level checks for the release time wakeup queue, bound to the top
`timescale 1ns / 1ps
`default_nettype none
module rtwq_checker import rtwq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [KIND_W-1:0] out_event_kind,
  input wire logic [TIME_W-1:0] out_next_expiry,
  input wire logic              out_last
);

  // no result and no acceptance right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  // delay results are always single words
  a_delay_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind != EV_WOKEN) |-> out_last)
    else $error("delay result without last");

  // words of one wake burst report the same expiry
  a_burst_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last ##1 out_valid |->
    $stable(out_next_expiry) || (out_event_kind != EV_WOKEN))
    else $error("wake burst expiry changed");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_expiry))
    else $error("stalled word dropped");

endmodule

bind release_time_wakeup_queue rtwq_checker u_rtwq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_kind  (out_event_kind),
  .out_next_expiry (out_next_expiry),
  .out_last        (out_last)
);
`default_nettype wire

[tb/sv/tb_release_time_wakeup_queue.sv]
// self-checking bench for the release time wakeup queue: random and directed words
`timescale 1ns / 1ps
module tb_release_time_wakeup_queue;
  import rtwq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int TASKS = TASK_COUNT_DEF;
  localparam logic [TIME_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic              command;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] rel;
    logic [TIME_W-1:0] now;
  } sched_word_t;

  typedef struct packed {
    event_kind_t       kind;
    logic [TASK_W-1:0] task_id;
    logic [JOB_W-1:0]  jobs;
    logic [TIME_W-1:0] expiry;
    logic              last;
  } sched_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [MARGIN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [TASK_W-1:0] in_task_id = '0;
  logic [TIME_W-1:0] in_release_time = '0;
  logic [TIME_W-1:0] in_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] out_event_kind;
  logic [TASK_W-1:0] out_task;
  logic [JOB_W-1:0] out_job_number;
  logic [TIME_W-1:0] out_next_expiry;
  logic out_last;

  release_time_wakeup_queue dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_task_id(in_task_id), .in_release_time(in_release_time), .in_now(in_now),
    .out_valid(out_valid), .out_ready(out_ready), .out_event_kind(out_event_kind),
    .out_task(out_task), .out_job_number(out_job_number),
    .out_next_expiry(out_next_expiry), .out_last(out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [TIME_W-1:0]   q_rel [DEPTH];
  logic [TASK_W-1:0]   q_task [DEPTH];
  int                  q_fill;
  logic [JOB_W-1:0]    job_count [TASKS];
  logic [TIME_W-1:0]   expiry;
  logic [MARGIN_W-1:0] margin;

  sched_word_t  pending_words[$];
  sched_event_t expected_events[$];
  int errors = 0;
  int n_words = 0, n_events = 0, n_wakes = 0, n_full = 0, n_late = 0;
  bit idle_en = 1'b1;
  bit rx_hold = 1'b0;
  bit tx_pause = 1'b0;

  function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a,
                                               logic [MARGIN_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {33'b0, b};
    return s[TIME_W] ? ALL_ONES : s[TIME_W-1:0];
  endfunction

  task automatic predict_word(sched_word_t w);
    int pos, woken, first;
    sched_event_t ev;
    logic [TIME_W-1:0] limit;
    if (w.command == CMD_DELAY) begin
      if (w.rel > w.now) begin
        if (q_fill >= DEPTH) begin
          ev = '{EV_FULL, w.task_id, job_count[w.task_id], expiry, 1'b1};
        end else begin
          pos = 0;
          while (pos < q_fill && q_rel[pos] <= w.rel) pos++;
          for (int i = q_fill; i > pos; i--) begin
            q_rel[i] = q_rel[i-1];
            q_task[i] = q_task[i-1];
          end
          q_rel[pos] = w.rel;
          q_task[pos] = w.task_id;
          q_fill++;
          if (q_rel[0] < add_sat(expiry, margin)) expiry = q_rel[0];
          ev = '{EV_QUEUED, w.task_id, job_count[w.task_id], expiry, 1'b1};
        end
      end else begin
        job_count[w.task_id]++;
        ev = '{EV_LATE, w.task_id, job_count[w.task_id], expiry, 1'b1};
      end
      expected_events.push_back(ev);
      return;
    end
    if (w.now < expiry) return;
    limit = add_sat(w.now, margin);
    woken = 0;
    first = expected_events.size();
    while (woken < q_fill && q_rel[woken] <= limit) begin
      job_count[q_task[woken]]++;
      ev = '{EV_WOKEN, q_task[woken], job_count[q_task[woken]], '0, 1'b0};
      expected_events.push_back(ev);
      woken++;
    end
    for (int i = woken; i < q_fill; i++) begin
      q_rel[i-woken] = q_rel[i];
      q_task[i-woken] = q_task[i];
    end
    q_fill -= woken;
    expiry = (q_fill > 0) ? q_rel[0] : ALL_ONES;
    // the whole burst reports the reloaded expiry
    for (int i = first; i < expected_events.size(); i++)
      expected_events[i].expiry = expiry;
    if (woken > 0) expected_events[expected_events.size()-1].last = 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_word({in_command, in_task_id, in_release_time, in_now});
        n_words++;
      end
      if ((!in_valid || in_ready) && pending_words.size() > 0 && !tx_pause &&
          !(idle_en && $urandom_range(99) < 11)) begin
        sched_word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_command <= w.command;
        in_task_id <= w.task_id;
        in_release_time <= w.rel;
        in_now <= w.now;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sched_event_t e;
        n_events++;
        if (expected_events.size() == 0) begin
          $error("unexpected word: kind %0d task %0d", out_event_kind, out_task);
          errors++;
        end else begin
          e = expected_events.pop_front();
          if (out_event_kind != e.kind) begin
            $error("event_kind: expected %0d actual %0d", e.kind, out_event_kind);
            errors++;
          end
          if (out_task != e.task_id) begin
            $error("out_task: expected %0d actual %0d", e.task_id, out_task);
            errors++;
          end
          if (out_job_number != e.jobs) begin
            $error("job_number: expected %0d actual %0d", e.jobs, out_job_number);
            errors++;
          end
          if (out_next_expiry != e.expiry) begin
            $error("next_expiry: expected %h actual %h", e.expiry, out_next_expiry);
            errors++;
          end
          if (out_last != e.last) begin
            $error("last: expected %0d actual %0d", e.last, out_last);
            errors++;
          end
          if (e.kind == EV_WOKEN) n_wakes++;
          if (e.kind == EV_FULL) n_full++;
          if (e.kind == EV_LATE) n_late++;
        end
      end
      out_ready <= !rx_hold && !(idle_en && $urandom_range(99) < 11);
    end
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic sched_word_t delay_word(logic [TASK_W-1:0] t, logic [TIME_W-1:0] r,
                                            logic [TIME_W-1:0] n);
    return '{CMD_DELAY, t, r, n};
  endfunction

  function automatic sched_word_t tick_word(logic [TIME_W-1:0] n);
    return '{CMD_TICK, TASK_W'($urandom), rand64(), n};
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    // empty ticks give no word, so allow the block to settle
    repeat (40) @(posedge clk);
  endtask

  task automatic write_margin(logic [MARGIN_W-1:0] m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    margin = m;
  endtask

  // one sequence of delays around a time base, then ticks that sweep past them
  task automatic push_sequence(int n_delay, logic [TIME_W-1:0] base, int spread);
    logic [TIME_W-1:0] t;
    t = base;
    for (int i = 0; i < n_delay; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 15)
        pending_words.push_back(delay_word(TASK_W'($urandom), t - $urandom_range(3), t));
      else if (r < 25)
        pending_words.push_back(delay_word(TASK_W'($urandom),
                                           t + 1 + 4 * $urandom_range(3), t));
      else
        pending_words.push_back(delay_word(TASK_W'($urandom),
                                           t + 1 + $urandom_range(spread), t));
    end
    for (int i = 0; i < 3; i++) begin
      t = t + $urandom_range(spread / 2);
      pending_words.push_back(tick_word(t));
    end
    pending_words.push_back(tick_word(t + spread + 64'd10));
  endtask

  initial begin
    for (int i = 0; i < TASKS; i++) job_count[i] = '0;
    q_fill = 0;
    expiry = ALL_ONES;
    margin = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    pending_words.push_back(tick_word(64'd0));
    pending_words.push_back(delay_word(6'd0, 64'd5, 64'd5));
    pending_words.push_back(delay_word(6'd63, 64'd0, ALL_ONES));
    pending_words.push_back(delay_word(6'd63, ALL_ONES, 64'd0));
    pending_words.push_back(delay_word(6'd1, 64'd100, 64'd0));
    pending_words.push_back(delay_word(6'd2, 64'd100, 64'd0));
    pending_words.push_back(delay_word(6'd1, 64'd50, 64'd0));
    pending_words.push_back(tick_word(64'd10));
    pending_words.push_back(tick_word(64'd100));
    pending_words.push_back(tick_word(64'hFFFF_FFFF_FFFF_FFFE));
    pending_words.push_back(tick_word(ALL_ONES));
    drain();
    write_margin(32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH + 2; i++)
      pending_words.push_back(delay_word(6'(i), 64'hFFFF_FFFF_FFFF_0000 + i, 64'd0));
    pending_words.push_back(tick_word(64'hFFFF_FFFF_0000_0000));
    drain();
    write_margin(32'd0);

    // random part, margin changed between phases
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        idle_en = 1'b0;
      end else begin
        idle_en = 1'b1;
      end
      if (ph == 5) begin
        // long receiver hold while the queue and result path fill
        rx_hold = 1'b1;
        push_sequence(20, rand64() >> 1, 1000);
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int k = 0; k < 4; k++)
        push_sequence($urandom_range(2, 12), ($urandom_range(1) ? rand64() :
                      64'($urandom)) >> 1, $urandom_range(1, 5) * 20 + margin);
      // a little noise
      pending_words.push_back(tick_word(rand64()));
      pending_words.push_back(delay_word(TASK_W'($urandom), rand64(), rand64()));
      if (ph == 6) begin
        while (pending_words.size() > 0) @(posedge clk);
        tx_pause = 1'b1;
        while (in_valid || expected_events.size() > 0) @(posedge clk);
        tx_pause = 1'b0;
      end
      drain();
      case (ph)
        0: write_margin(32'd3);
        1: write_margin(32'hFFFF_FFFF);
        2: write_margin(32'd0);
        default: write_margin($urandom_range(1, 200));
      endcase
    end
    pending_words.push_back(tick_word(ALL_ONES));
    drain();

    $display("%0d words in, %0d results (%0d woken, %0d late, %0d full)",
             n_words, n_events, n_wakes, n_late, n_full);
    if (errors == 0) begin
      $display("release_time_wakeup_queue regression: pass");
    end else begin
      $display("release_time_wakeup_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("release_time_wakeup_queue regression: fail");
    $finish;
  end

endmodule

[files.f]
sv/rtwq_pkg.sv
sv/rtwq_ram.sv
sv/rtwq_front.sv
sv/rtwq_back.sv
sv/release_time_wakeup_queue.sv
sv/rtwq_checker.sv
tb/sv/tb_release_time_wakeup_queue.sv
